### sv/tls_pkg.sv
// shared types, constants and helpers for the text line splitter
`default_nettype none

package tls_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_SEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_STRIP_ON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_CODE     = 3'd4;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_PRIMARY_SEP = 8'd10;
    localparam logic              RST_SECOND_ON   = 1'b0;
    localparam logic [BYTE_W-1:0] RST_SECOND_SEP  = 8'd0;
    localparam logic              RST_CR_STRIP_ON = 1'b1;
    localparam logic [BYTE_W-1:0] RST_CR_CODE     = 8'd13;

    // one result record
    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
        logic              line_end;
        logic [LEN_W-1:0]  line_length;
        logic              ended_with_cr;
        logic              was_split;
        logic              last;
    } t_result;

    // content byte record
    function automatic t_result make_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        r               = '0;
        r.has_byte      = 1'b1;
        r.out_byte      = b;
        return r;
    endfunction

    // line end record
    function automatic t_result make_end(input logic [LEN_W-1:0] len,
                                         input logic cr, input logic split);
        t_result r;
        r               = '0;
        r.line_end      = 1'b1;
        r.line_length   = len;
        r.ended_with_cr = cr;
        r.was_split     = split;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/tls_in_if.sv
// input byte channel
`default_nettype none

interface tls_in_if import tls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### sv/tls_out_if.sv
// result record channel
`default_nettype none

interface tls_out_if import tls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              has_byte;
    logic [BYTE_W-1:0] out_byte;
    logic              line_end;
    logic [LEN_W-1:0]  line_length;
    logic              ended_with_cr;
    logic              was_split;
    logic              last;

    modport source (output valid, output has_byte, output out_byte, output line_end,
                    output line_length, output ended_with_cr, output was_split,
                    output last, input ready);
    modport sink   (input valid, input has_byte, input out_byte, input line_end,
                    input line_length, input ended_with_cr, input was_split,
                    input last, output ready);
endinterface

`default_nettype wire

### sv/text_line_splitter_top.sv
// text line splitter top level: byte stream in, content bytes and line end records out
//
//  channel    | dir | transaction
//  i_data_ch  | in  | one text byte
//  o_res_ch   | out | one content byte or one line end record
//  i_cfg_*    | in  | register write, no handshake
//
// a byte is taken whenever the result queue has room for two records;
// its records are written straight into a 4-entry queue whose head drives o_res_ch
// one record leaves per cycle while o_res_ch is ready, so a byte that releases both a content
// byte and a line end record holds the output for both records; all other bytes sustain one per cycle
// reset is synchronous: queue empties, nothing held, line count zero, registers at defaults
// a stalled output only stops input once fewer than two queue entries are free
`default_nettype none

module text_line_splitter_top import tls_pkg::*; #(
    parameter int MAX_LINE_LEN = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tls_in_if.sink                     i_data_ch,
    tls_out_if.source                  o_res_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_LINE_LEN + 1);
    localparam int EW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LINE_LEN);
    localparam int QD = 4;
    localparam int QA = 2;

    // configuration registers
    logic [BYTE_W-1:0] r_primary_sep;
    logic              r_second_on;
    logic [BYTE_W-1:0] r_second_sep;
    logic              r_cr_strip_on;
    logic [BYTE_W-1:0] r_cr_code;

    // line state
    logic [BYTE_W-1:0] r_held_byte, n_held_byte;
    logic              r_held_valid, n_held_valid;
    logic              r_held_cr, n_held_cr;
    logic [CW-1:0]     r_count, n_count;

    // result queue
    t_result           r_queue [QD];
    logic [QA-1:0]     r_wr_ptr;
    logic [QA-1:0]     r_rd_ptr;
    logic [QA:0]       r_fill;

    logic              w_in_fire;
    logic              w_out_fire;
    logic [1:0]        w_push_n;
    t_result           w_res0, w_res1;
    t_result           w_head;

    logic [BYTE_W-1:0] w_b;
    logic              w_is_sep;
    logic              w_new_cr;
    logic              w_pre_split;
    logic              w_post_split;
    logic [CW-1:0]     w_count_inc;
    logic [CW-1:0]     w_count_after;
    logic [EW-1:0]     w_cnt_ext, w_inc_ext, w_max_ext;
    logic [LEN_W-1:0]  w_len_cur, w_len_inc, w_len_max;

    // handshakes
    assign i_data_ch.ready = (r_fill <= (QA+1)'(QD - 2));
    assign w_in_fire       = i_data_ch.valid && i_data_ch.ready;
    assign w_out_fire      = o_res_ch.valid && o_res_ch.ready;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_sep <= RST_PRIMARY_SEP;
            r_second_on   <= RST_SECOND_ON;
            r_second_sep  <= RST_SECOND_SEP;
            r_cr_strip_on <= RST_CR_STRIP_ON;
            r_cr_code     <= RST_CR_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRIMARY_SEP: r_primary_sep <= i_cfg_data;
                CFG_SECOND_ON:   r_second_on   <= i_cfg_data[0];
                CFG_SECOND_SEP:  r_second_sep  <= i_cfg_data;
                CFG_CR_STRIP_ON: r_cr_strip_on <= i_cfg_data[0];
                CFG_CR_CODE:     r_cr_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // byte classification and count arithmetic
    assign w_b         = i_data_ch.data_byte;
    assign w_is_sep    = (w_b == r_primary_sep) || (r_second_on && (w_b == r_second_sep));
    assign w_new_cr    = r_cr_strip_on && (w_b == r_cr_code);
    assign w_count_inc = CW'(r_count + 1'b1);
    assign w_pre_split = r_held_valid && (r_count >= MAX_C);
    assign w_count_after = !r_held_valid ? r_count :
                           (w_pre_split ? CW'(1) : w_count_inc);
    assign w_post_split  = !w_new_cr && (w_count_after >= MAX_C);

    // lengths folded to the output field width
    assign w_cnt_ext = EW'(r_count);
    assign w_inc_ext = EW'(w_count_inc);
    assign w_max_ext = EW'(MAX_C);
    assign w_len_cur = w_cnt_ext[LEN_W-1:0];
    assign w_len_inc = w_inc_ext[LEN_W-1:0];
    assign w_len_max = w_max_ext[LEN_W-1:0];

    // records caused by the incoming byte and next line state
    always_comb begin
        w_res0       = '0;
        w_res1       = '0;
        w_push_n     = 2'd0;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_cr    = r_held_cr;
        n_count      = r_count;
        if (w_is_sep) begin
            if (r_held_valid && r_held_cr) begin
                // stripped cr closes the line
                w_res0   = make_end(w_len_cur, 1'b1, 1'b0);
                w_push_n = 2'd1;
            end else if (r_held_valid) begin
                w_res0   = make_byte(r_held_byte);
                w_res1   = make_end(w_len_inc, 1'b0, 1'b0);
                w_push_n = 2'd2;
            end else begin
                w_res0   = make_end(w_len_cur, 1'b0, 1'b0);
                w_push_n = 2'd1;
            end
            n_held_byte  = '0;
            n_held_valid = 1'b0;
            n_held_cr    = 1'b0;
            n_count      = '0;
        end else begin
            if (w_pre_split) begin
                // full line closes before the held byte
                w_res0   = make_end(w_len_max, 1'b0, 1'b1);
                w_res1   = make_byte(r_held_byte);
                w_push_n = 2'd2;
            end else if (r_held_valid) begin
                w_res0   = make_byte(r_held_byte);
                w_res1   = make_end(w_len_max, 1'b0, 1'b1);
                w_push_n = w_post_split ? 2'd2 : 2'd1;
            end else if (w_post_split) begin
                w_res0   = make_end(w_len_max, 1'b0, 1'b1);
                w_push_n = 2'd1;
            end
            n_held_byte  = w_b;
            n_held_valid = 1'b1;
            n_held_cr    = w_new_cr;
            n_count      = w_post_split ? '0 : w_count_after;
        end
        // mark the final record of this byte
        if (w_push_n == 2'd1) begin
            w_res0.last = 1'b1;
        end
        if (w_push_n == 2'd2) begin
            w_res1.last = 1'b1;
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_held_cr    <= 1'b0;
            r_count      <= '0;
        end else if (w_in_fire) begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_held_cr    <= n_held_cr;
            r_count      <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_in_fire && (w_push_n != 2'd0)) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_in_fire && (w_push_n == 2'd2)) begin
            r_queue[QA'(r_wr_ptr + 1'b1)] <= w_res1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_in_fire) begin
                r_wr_ptr <= QA'(r_wr_ptr + w_push_n);
            end
            if (w_out_fire) begin
                r_rd_ptr <= QA'(r_rd_ptr + 1'b1);
            end
            r_fill <= (QA+1)'(r_fill + (w_in_fire ? (QA+1)'(w_push_n) : '0)
                      - (QA+1)'(w_out_fire));
        end
    end

    // queue head drives the output channel
    assign w_head                 = r_queue[r_rd_ptr];
    assign o_res_ch.valid         = (r_fill != '0);
    assign o_res_ch.has_byte      = w_head.has_byte;
    assign o_res_ch.out_byte      = w_head.out_byte;
    assign o_res_ch.line_end      = w_head.line_end;
    assign o_res_ch.line_length   = w_head.line_length;
    assign o_res_ch.ended_with_cr = w_head.ended_with_cr;
    assign o_res_ch.was_split     = w_head.was_split;
    assign o_res_ch.last          = w_head.last;

endmodule

`default_nettype wire

### dv/tb_text_line_splitter_top.sv
// testbench for the text line splitter: directed and random byte streams checked by a line model
module tb_text_line_splitter_top;
    import tls_pkg::*;

    localparam int     MAX_LEN       = 1024;
    localparam int     HALF_PERIOD   = 6;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     RANDOM_BYTES  = 500;
    localparam int     N_SETTINGS    = 7;
    localparam int     MAX_REPORTS   = 10;
    localparam longint LIMIT_UNITS   = 30_000_000;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} t_pace;
    typedef enum int {TAIL_PRIMARY, TAIL_SECOND, TAIL_CR, TAIL_NONE} t_tail;

    // line model and store of expected records
    class line_split_board;
        logic [BYTE_W-1:0] primary_sep;
        logic              second_on;
        logic [BYTE_W-1:0] second_sep;
        logic              cr_strip;
        logic [BYTE_W-1:0] cr_code;
        logic [BYTE_W-1:0] held_byte;
        logic              held_valid;
        logic              held_cr;
        int                line_count;
        t_result           step_recs[$];
        t_result           line_records[$];
        int                errors;

        function new();
            primary_sep = RST_PRIMARY_SEP;
            second_on   = RST_SECOND_ON;
            second_sep  = RST_SECOND_SEP;
            cr_strip    = RST_CR_STRIP_ON;
            cr_code     = RST_CR_CODE;
            held_byte   = '0;
            held_valid  = 1'b0;
            held_cr     = 1'b0;
            line_count  = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRIMARY_SEP: primary_sep = data[BYTE_W-1:0];
                CFG_SECOND_ON:   second_on   = data[0];
                CFG_SECOND_SEP:  second_sep  = data[BYTE_W-1:0];
                CFG_CR_STRIP_ON: cr_strip    = data[0];
                CFG_CR_CODE:     cr_code     = data[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit is_separator(logic [BYTE_W-1:0] b);
            return (b == primary_sep) || (second_on && b == second_sep);
        endfunction

        function void emit_content(logic [BYTE_W-1:0] b);
            t_result r;
            r          = '0;
            r.has_byte = 1'b1;
            r.out_byte = b;
            step_recs.push_back(r);
        endfunction

        function void emit_close(int len, logic cr, logic split);
            t_result r;
            r               = '0;
            r.line_end      = 1'b1;
            r.line_length   = LEN_W'(len);
            r.ended_with_cr = cr;
            r.was_split     = split;
            step_recs.push_back(r);
        endfunction

        // one accepted byte: the held byte goes out unless it is a stripped cr, and a non-separator byte is held
        function void split_byte(logic [BYTE_W-1:0] b);
            t_result r;
            step_recs.delete();
            if (is_separator(b)) begin
                if (held_valid && held_cr) begin
                    emit_close(line_count, 1'b1, 1'b0);
                end else begin
                    if (held_valid) begin
                        emit_content(held_byte);
                        line_count++;
                    end
                    emit_close(line_count, 1'b0, 1'b0);
                end
                line_count = 0;
                held_valid = 1'b0;
                held_cr    = 1'b0;
                held_byte  = '0;
            end else begin
                if (held_valid) begin
                    // a full line is cut before the held byte goes out
                    if (line_count >= MAX_LEN) begin
                        emit_close(MAX_LEN, 1'b0, 1'b1);
                        line_count = 0;
                    end
                    emit_content(held_byte);
                    line_count++;
                end
                held_byte  = b;
                held_valid = 1'b1;
                held_cr    = cr_strip && (b == cr_code);
                if (!held_cr && line_count >= MAX_LEN) begin
                    emit_close(MAX_LEN, 1'b0, 1'b1);
                    line_count = 0;
                end
            end
            // flag the final record of this byte
            if (step_recs.size() > 0) begin
                r      = step_recs.pop_back();
                r.last = 1'b1;
                step_recs.push_back(r);
            end
            foreach (step_recs[i]) line_records.push_back(step_recs[i]);
        endfunction

        function string show(t_result r);
            return $sformatf("has_byte=%0d byte=%02h end=%0d len=%0d cr=%0d split=%0d last=%0d",
                             r.has_byte, r.out_byte, r.line_end, r.line_length,
                             r.ended_with_cr, r.was_split, r.last);
        endfunction

        // compare one output record with the oldest expected one
        function void check_record(t_result got);
            t_result want;
            if (line_records.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("record with nothing expected: %s", show(got));
            end else begin
                want = line_records.pop_front();
                if (got.has_byte !== want.has_byte || got.out_byte !== want.out_byte ||
                    got.line_end !== want.line_end || got.line_length !== want.line_length ||
                    got.ended_with_cr !== want.ended_with_cr ||
                    got.was_split !== want.was_split || got.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("record mismatch");
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        endfunction

        function int pending();
            return line_records.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tls_in_if  data_ch();
    tls_out_if res_ch();

    line_split_board board = new();
    t_pace           tx_pace;
    t_pace           rx_pace;
    int              cr_pct;
    int              bytes_sent;

    text_line_splitter_top #(.MAX_LINE_LEN(MAX_LEN)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data_ch  (data_ch),
        .o_res_ch   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    function automatic int draw_wait(t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 16);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // content byte that is not a separator, sometimes the cr code
    function automatic logic [BYTE_W-1:0] pick_content();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if ($urandom_range(0, 99) < cr_pct) b = board.cr_code;
        while (board.is_separator(b)) b = BYTE_W'($urandom);
        return b;
    endfunction

    // one input transaction, after a gap drawn for the input pace
    task automatic send_byte(logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        data_ch.data_byte <= b;
        data_ch.valid     <= 1'b1;
        @(posedge i_clk);
        while (!data_ch.ready) @(posedge i_clk);
        board.split_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(int len, t_tail tail);
        int i;
        for (i = 0; i < len; i++) send_byte(pick_content());
        case (tail)
            TAIL_PRIMARY: send_byte(board.primary_sep);
            TAIL_SECOND:  send_byte(board.second_on ? board.second_sep : board.primary_sep);
            TAIL_CR: begin
                send_byte(board.cr_code);
                send_byte(board.primary_sep);
            end
            default: ;
        endcase
    endtask

    // hold input until every expected record is out, then let the pipe settle
    task automatic wait_drained();
        data_ch.valid <= 1'b0;
        while (board.pending() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // all five registers, junk in unused bits, plus a write to an unmapped index
    task automatic load_setting(logic [BYTE_W-1:0] primary, logic sec_on,
                                logic [BYTE_W-1:0] sec, logic strip, logic [BYTE_W-1:0] cr);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        wait_drained();
        write_reg(CFG_PRIMARY_SEP, primary);
        write_reg(CFG_SECOND_ON, {junk[CFG_DATA_W-1:1], sec_on});
        write_reg(CFG_SECOND_SEP, sec);
        write_reg(CFG_CR_STRIP_ON, {~junk[CFG_DATA_W-1:1], strip});
        write_reg(CFG_CR_CODE, cr);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_CR_CODE) + 1, (1 << CFG_IDX_W) - 1)),
                  junk);
    endtask

    // output side: stalls drawn for the output pace, every accepted record checked
    initial begin : result_sink
        int      stall;
        t_result got;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(rx_pace);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            got.has_byte      = res_ch.has_byte;
            got.out_byte      = res_ch.out_byte;
            got.line_end      = res_ch.line_end;
            got.line_length   = res_ch.line_length;
            got.ended_with_cr = res_ch.ended_with_cr;
            got.was_split     = res_ch.was_split;
            got.last          = res_ch.last;
            board.check_record(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int                p;
        int                len;
        int                pick;
        int                target;
        logic [BYTE_W-1:0] s1;
        logic [BYTE_W-1:0] s2;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        data_ch.valid     = 1'b0;
        data_ch.data_byte = '0;
        tx_pace           = PACE_SPARSE;
        rx_pace           = PACE_RANDOM;
        cr_pct            = 10;
        bytes_sent        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stripped cr, empty line, doubled cr, byte extremes, cr inside a line
        send_byte("a"); send_byte("b"); send_byte(CH_CR); send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(CH_CR); send_byte(CH_CR); send_byte(CH_LF);
        send_byte(8'h00); send_byte(8'hFF); send_byte(CH_LF);
        send_byte(CH_CR); send_byte("y"); send_byte(CH_LF);

        // cr decision stays with the settings at its arrival
        send_byte("q"); send_byte(CH_CR);
        wait_drained();
        write_reg(CFG_CR_STRIP_ON, 8'h00);
        send_byte(CH_LF);

        // second separator, then a byte that is both separator and cr code
        wait_drained();
        write_reg(CFG_CR_STRIP_ON, 8'h01);
        write_reg(CFG_SECOND_ON, 8'h01);
        write_reg(CFG_SECOND_SEP, 8'h00);
        send_byte("z"); send_byte(8'h00);
        wait_drained();
        write_reg(CFG_CR_CODE, 8'h00);
        send_byte("w"); send_byte(8'h00);

        // random lines under a series of register settings
        for (p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: load_setting(8'h0A, 1'b1, 8'h3B, 1'b1, 8'h0D);
                1: load_setting(8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF);
                2: load_setting(8'hFF, 1'b1, 8'h00, 1'b0, 8'h0D);
                3: begin
                    s1 = BYTE_W'($urandom);
                    s2 = BYTE_W'($urandom);
                    load_setting(s1, 1'b1, s2, 1'b1, s2);
                end
                4: begin
                    s1 = BYTE_W'($urandom);
                    load_setting(s1, 1'b0, s1 ^ 8'h5A, 1'b1, s1);
                end
                5: load_setting(8'hFF, 1'b1, 8'hFE, 1'b1, 8'h00);
                default: begin
                    s1 = BYTE_W'($urandom);
                    s2 = BYTE_W'($urandom);
                    load_setting(s1, 1'b1, s2, 1'b1, BYTE_W'($urandom));
                end
            endcase
            tx_pace = t_pace'(p % 3);
            rx_pace = t_pace'((p + 1) % 3);
            cr_pct  = $urandom_range(5, 30);
            target  = bytes_sent + RANDOM_BYTES / N_SETTINGS;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
                if (pick < 6) begin
                    send_byte(BYTE_W'($urandom));
                end else if (pick < 8) begin
                    wait_drained();
                end else begin
                    send_line(len, t_tail'($urandom_range(0, 3)));
                end
            end
        end

        // close the open line and let everything come out
        send_byte(board.primary_sep);
        wait_drained();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[text_line_splitter_top] OK");
        end else begin
            $display("[text_line_splitter_top] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(LIMIT_UNITS);
        $display("[text_line_splitter_top] ERROR");
        $finish;
    end

endmodule

### text_line_splitter_top.f
sv/tls_pkg.sv
sv/tls_in_if.sv
sv/tls_out_if.sv
sv/text_line_splitter_top.sv
dv/tb_text_line_splitter_top.sv
